// ----- src/pse_pkg.sv -----
// Shared types and constants for the postfix stack evaluator.
// No dependencies; imported by every module in src.
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int FUNC_W      = 3;
    localparam int VALUE_W     = 31;
    localparam int TOP_W       = 32;
    localparam int DEPTH_OUT_W = 5;

    localparam logic [FUNC_W-1:0] FN_NUM = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV = 3'd4;

    typedef enum logic [2:0] {
        TK_NUM,
        TK_ADD,
        TK_SUB,
        TK_MUL,
        TK_DIV,
        TK_NOP
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t             kind;
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
    } token_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } back_state_t;

endpackage

// ----- src/postfix_stack_evaluator_unit.sv -----
// Postfix / prefix expression evaluator over a 16-entry operand stack.
//
// Input channel s_*: one token per beat (s_func, s_operand_value, s_last).
// Result channel m_*: exactly one result beat per token, in token order,
// giving the stack top and depth after the token plus status flags.
// cfg_we / cfg_wdata write the operand order (0 postfix, 1 prefix); write it
// only while no token is in flight.
//
// Tokens pass a decode register and a two-entry queue before execution.
// Number, add, subtract, multiply, unknown and divide-by-zero tokens execute
// without the divider, so a stream of them sustains one token per cycle
// while m_ready keeps the results flowing. A divide with a nonzero divisor
// runs the bit-serial divider; the stack top is needed by the next token,
// so execution waits for the quotient.
// Reset (aresetn low at a clock edge) empties the stack, drops all tokens
// in flight and sets postfix order. If m_ready stays low, one result is
// held in the output register, the queue and decode register fill up and
// then s_ready drops.
// Depends on pse_pkg, pse_front, pse_fifo, pse_back (and pse_div).
module postfix_stack_evaluator_unit
    import pse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FUNC_W-1:0]       s_func,
    input  logic [VALUE_W-1:0]      s_operand_value,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TOP_W-1:0] m_top_value,
    output logic [DEPTH_OUT_W-1:0]  m_stack_depth,
    output logic                    m_underflow,
    output logic                    m_overflow,
    output logic                    m_divide_by_zero,
    output logic                    m_answer_valid
);

    logic   fr_valid, fr_ready;
    token_t fr_tok;
    logic   q_valid, q_ready;
    token_t q_tok;

    pse_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_operand_value (s_operand_value),
        .s_last          (s_last),
        .tok_valid       (fr_valid),
        .tok_ready       (fr_ready),
        .tok             (fr_tok)
    );

    pse_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_tok),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_tok)
    );

    pse_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .tok_valid        (q_valid),
        .tok_ready        (q_ready),
        .tok              (q_tok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_top_value      (m_top_value),
        .m_stack_depth    (m_stack_depth),
        .m_underflow      (m_underflow),
        .m_overflow       (m_overflow),
        .m_divide_by_zero (m_divide_by_zero),
        .m_answer_valid   (m_answer_valid)
    );

endmodule

// ----- src/pse_front.sv -----
// Front end: takes input beats, decodes the token kind and holds one token
// until the queue takes it. Depends on pse_pkg.
module pse_front
    import pse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FUNC_W-1:0]  s_func,
    input  logic [VALUE_W-1:0] s_operand_value,
    input  logic               s_last,
    output logic               tok_valid,
    input  logic               tok_ready,
    output token_t             tok
);

    logic      valid_reg;
    token_t    tok_reg;
    tok_kind_t kind_dec;

    always_comb begin
        case (s_func)
            FN_NUM:  kind_dec = TK_NUM;
            FN_ADD:  kind_dec = TK_ADD;
            FN_SUB:  kind_dec = TK_SUB;
            FN_MUL:  kind_dec = TK_MUL;
            FN_DIV:  kind_dec = TK_DIV;
            default: kind_dec = TK_NOP;
        endcase
    end

    assign s_ready   = !valid_reg || tok_ready;
    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (tok_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tok_reg.kind  <= kind_dec;
            tok_reg.value <= DATA_WIDTH'(s_operand_value);
            tok_reg.last  <= s_last;
        end
    end

endmodule

// ----- src/pse_fifo.sv -----
// Two-entry token queue between the front end and the execution back end.
// Depends on pse_pkg.
module pse_fifo
    import pse_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  token_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output token_t rd_data
);

    token_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/pse_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg.
module pse_div
    import pse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient
);

    localparam int STEP_W = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  neg_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] mag_b_reg;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic                  na;
    logic                  nb;

    assign na     = dividend[DATA_WIDTH-1];
    assign nb     = divisor[DATA_WIDTH-1];
    assign rem_sh = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, mag_b_reg};

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_WIDTH'(0) - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DATA_WIDTH);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // magnitudes are taken as unsigned, so the most negative value still works
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg   <= na ^ nb;
            rem_reg   <= '0;
            quo_reg   <= na ? (DATA_WIDTH'(0) - dividend) : dividend;
            mag_b_reg <= nb ? (DATA_WIDTH'(0) - divisor) : divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], !diff[DATA_WIDTH]};
        end
    end

endmodule

// ----- src/pse_back.sv -----
// Execution back end: operand stack, ALU, divider control and result register.
// Depends on pse_pkg and pse_div.
module pse_back
    import pse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    tok_valid,
    output logic                    tok_ready,
    input  token_t                  tok,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TOP_W-1:0] m_top_value,
    output logic [DEPTH_OUT_W-1:0]  m_stack_depth,
    output logic                    m_underflow,
    output logic                    m_overflow,
    output logic                    m_divide_by_zero,
    output logic                    m_answer_valid
);

    localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

    back_state_t           st_reg, st_next;
    logic                  order_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];

    logic                  pend_under_reg, pend_under_next;
    logic                  pend_last_reg, pend_last_next;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_top_reg;
    logic [CNT_W-1:0]      out_depth_reg;
    logic                  out_under_reg;
    logic                  out_over_reg;
    logic                  out_dz_reg;
    logic                  out_ans_reg;

    logic                  out_free;
    logic                  load_out;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [CNT_W-1:0]      cnt_op;
    logic [DATA_WIDTH-1:0] top_op;
    logic                  last_op;
    logic                  o_under, o_over, o_dz;

    logic                  has_two;
    logic [DATA_WIDTH-1:0] first_v, second_v, lhs, rhs, alu_res;
    logic                  div_start, div_busy, div_done;
    logic [DATA_WIDTH-1:0] div_q;

    assign has_two  = (count_reg >= CNT_W'(2));
    assign first_v  = (count_reg == '0) ? ALL_ONES : top_reg;
    assign second_v = has_two ? stack_mem[IDX_W'(count_reg - CNT_W'(2))] : ALL_ONES;
    assign lhs      = order_reg ? first_v : second_v;
    assign rhs      = order_reg ? second_v : first_v;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        case (tok.kind)
            TK_ADD:  alu_res = lhs + rhs;
            TK_SUB:  alu_res = lhs - rhs;
            TK_MUL:  alu_res = lhs * rhs;
            default: alu_res = ALL_ONES; // divide by zero
        endcase
    end

    pse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lhs),
        .divisor  (rhs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        st_next         = st_reg;
        tok_ready       = 1'b0;
        div_start       = 1'b0;
        load_out        = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = IDX_W'(count_reg);
        wr_data         = tok.value;
        cnt_op          = count_reg;
        top_op          = top_reg;
        last_op         = tok.last;
        o_under         = 1'b0;
        o_over          = 1'b0;
        o_dz            = 1'b0;
        pend_under_next = pend_under_reg;
        pend_last_next  = pend_last_reg;
        count_next      = count_reg;
        top_next        = top_reg;

        case (st_reg)
            BK_IDLE: begin
                if (tok_valid && out_free) begin
                    tok_ready = 1'b1;
                    case (tok.kind)
                        TK_NUM: begin
                            load_out = 1'b1;
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                o_over = 1'b1;
                            end else begin
                                wr_en  = 1'b1;
                                cnt_op = count_reg + CNT_W'(1);
                                top_op = tok.value;
                            end
                        end
                        TK_ADD, TK_SUB, TK_MUL, TK_DIV: begin
                            if (tok.kind == TK_DIV && rhs != '0) begin
                                // pop both now, push the quotient when it is ready
                                div_start       = 1'b1;
                                pend_under_next = !has_two;
                                pend_last_next  = tok.last;
                                count_next      = has_two ? count_reg - CNT_W'(2) : '0;
                                st_next         = BK_DIV;
                            end else begin
                                load_out = 1'b1;
                                o_under  = !has_two;
                                o_dz     = (tok.kind == TK_DIV);
                                wr_en    = 1'b1;
                                wr_idx   = has_two ? IDX_W'(count_reg - CNT_W'(2)) : '0;
                                wr_data  = alu_res;
                                cnt_op   = has_two ? count_reg - CNT_W'(1) : CNT_W'(1);
                                top_op   = alu_res;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_DIV: begin
                last_op = pend_last_reg;
                o_under = pend_under_reg;
                if (div_done && out_free) begin
                    load_out = 1'b1;
                    wr_en    = 1'b1;
                    wr_data  = div_q;
                    cnt_op   = count_reg + CNT_W'(1);
                    top_op   = div_q;
                    st_next  = BK_IDLE;
                end
            end
            default: begin
                st_next = BK_IDLE;
            end
        endcase

        if (load_out) begin
            count_next = last_op ? '0 : cnt_op;
            top_next   = top_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= BK_IDLE;
            order_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            count_reg <= count_next;
            if (cfg_we) begin
                order_reg <= cfg_wdata;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg        <= top_next;
        pend_under_reg <= pend_under_next;
        pend_last_reg  <= pend_last_next;
        if (wr_en) begin
            stack_mem[wr_idx] <= wr_data;
        end
        if (load_out) begin
            out_top_reg   <= (cnt_op == '0) ? ALL_ONES : top_op;
            out_depth_reg <= last_op ? '0 : cnt_op;
            out_under_reg <= o_under;
            out_over_reg  <= o_over;
            out_dz_reg    <= o_dz;
            out_ans_reg   <= last_op;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_top_value      = TOP_W'(signed'(out_top_reg));
    assign m_stack_depth    = DEPTH_OUT_W'(out_depth_reg);
    assign m_underflow      = out_under_reg;
    assign m_overflow       = out_over_reg;
    assign m_divide_by_zero = out_dz_reg;
    assign m_answer_valid   = out_ans_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_answer_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ans_reg |-> out_depth_reg == '0)
        else $error("answer beat with nonempty stack");

    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == BK_DIV |-> div_busy || div_done)
        else $error("waiting on a divider that was not started");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> st_reg == BK_DIV && div_busy)
        else $error("divider start without divide wait");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_over_reg && (out_under_reg || out_dz_reg)))
        else $error("push flag together with operator flag");

endmodule
